// ===== design/assert_macros.svh =====
// Assertion macros shared by the flash record slot scanner RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset disable
`define FSRS_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition that must never hold outside reset
`define FSRS_NEVER(name, clk, rstn, cond, msg) \
    `FSRS_ASSERT(name, clk, rstn, !(cond), msg)

`endif

// ===== design/fsrs_pkg.sv =====
// Types, constants and the CRC byte step of the flash record slot scanner.
// Depends on nothing; used by every module of the block.
`default_nettype none

package fsrs_pkg;

    // Widths fixed by the transfer formats and register map
    localparam int NEED_W      = 12;
    localparam int LEGACY_W    = 11;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int HDR_BYTES   = 16;

    localparam logic [31:0] CRC_POLY         = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT         = 32'hFFFF_FFFF;
    localparam logic [31:0] MAGIC_RESET      = 32'h5631_4346;
    localparam logic [LEGACY_W-1:0] LEGACY_LEN_RESET = 11'd1418;
    localparam logic [NEED_W-1:0]   CURRENT_EXTRA    = 12'd16;
    localparam logic [15:0] VER_LEGACY       = 16'h0012;
    localparam logic [15:0] VER_CURRENT      = 16'h0013;
    localparam logic [7:0]  ERASED_BYTE      = 8'hFF;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RECORD_MAGIC = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LEGACY_LEN   = 1'd1;

    // Boot status codes
    localparam logic [1:0] BOOT_VALID   = 2'd0;
    localparam logic [1:0] BOOT_VIRGIN  = 2'd1;
    localparam logic [1:0] BOOT_CORRUPT = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       page_end;
        logic       scan_end;
    } in_item_t;

    typedef struct packed {
        logic        record_found;
        logic [1:0]  best_slot;
        logic [31:0] best_sequence;
        logic        best_is_current;
        logic [3:0]  valid_mask;
        logic [1:0]  boot_status;
    } result_t;

    // Page parser to slot tracker
    typedef struct packed {
        logic        done;
        logic        ok;
        logic [31:0] sequence_no;
        logic        is_current;
        logic        byte_not_erased;
    } page_status_t;

    // One byte of reflected CRC-32, unrolled over eight bit steps
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/fsrs_page_parser.sv =====
// Per-page parser: byte offset, header capture, payload CRC and page verdict.
// Depends on fsrs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fsrs_page_parser #(
    parameter int PAGE_BYTES = 2048
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            fire,
    input  wire fsrs_pkg::in_item_t              item,
    input  wire logic                            slot_active,
    input  wire logic [31:0]                     record_magic,
    input  wire logic [fsrs_pkg::LEGACY_W-1:0]   legacy_len,
    output fsrs_pkg::page_status_t               status
);

    localparam int OFF_W = $clog2(PAGE_BYTES + 1);
    localparam int CMP_W = (OFF_W > fsrs_pkg::NEED_W + 1) ? OFF_W : fsrs_pkg::NEED_W + 1;

    logic [OFF_W-1:0] offset_reg,   offset_next;
    logic [31:0]      crc_reg,      crc_next;
    logic [31:0]      magic_reg,    magic_next;
    logic [15:0]      version_reg,  version_next;
    logic [15:0]      length_reg,   length_next;
    logic [31:0]      seq_reg,      seq_next;
    logic [31:0]      checksum_reg, checksum_next;

    logic                        take;
    logic                        in_hdr;
    logic                        in_payload;
    logic                        page_done;
    logic [fsrs_pkg::NEED_W-1:0] need;
    logic [CMP_W-1:0]            need_end;
    logic [31:0]                 crc_after;
    logic [OFF_W-1:0]            off_after;
    logic [4:0]                  lane_base;

    // Expected payload length for the captured version
    always_comb
    begin
        if (version_reg == fsrs_pkg::VER_CURRENT)
            need = fsrs_pkg::NEED_W'(legacy_len) + fsrs_pkg::CURRENT_EXTRA;
        else if (version_reg == fsrs_pkg::VER_LEGACY)
            need = fsrs_pkg::NEED_W'(legacy_len);
        else
            need = '0;
    end

    // Classify the byte in flight
    assign take       = fire && slot_active && (offset_reg < OFF_W'(PAGE_BYTES));
    assign in_hdr     = offset_reg < OFF_W'(fsrs_pkg::HDR_BYTES);
    assign need_end   = CMP_W'(need) + CMP_W'(fsrs_pkg::HDR_BYTES);
    assign in_payload = !in_hdr && (CMP_W'(offset_reg) < need_end);
    assign page_done  = fire && (item.page_end || item.scan_end);
    assign lane_base  = {offset_reg[1:0], 3'b000};

    assign crc_after = (take && in_payload) ? fsrs_pkg::crc_byte(crc_reg, item.data_byte)
                                            : crc_reg;
    assign off_after = take ? offset_reg + OFF_W'(1) : offset_reg;

    // Capture header lanes, advance offset, clear at page end
    always_comb
    begin
        magic_next    = magic_reg;
        version_next  = version_reg;
        length_next   = length_reg;
        seq_next      = seq_reg;
        checksum_next = checksum_reg;
        if (take && in_hdr)
        begin
            case (offset_reg[3:2])
                2'd0: magic_next[lane_base +: 8] = item.data_byte;
                2'd1:
                begin
                    if (offset_reg[1])
                        length_next[{offset_reg[0], 3'b000} +: 8] = item.data_byte;
                    else
                        version_next[{offset_reg[0], 3'b000} +: 8] = item.data_byte;
                end
                2'd2: seq_next[lane_base +: 8] = item.data_byte;
                2'd3: checksum_next[lane_base +: 8] = item.data_byte;
                default: magic_next = magic_reg;
            endcase
        end
        offset_next = off_after;
        crc_next    = crc_after;
        if (page_done)
        begin
            offset_next   = '0;
            crc_next      = fsrs_pkg::CRC_INIT;
            magic_next    = '0;
            version_next  = '0;
            length_next   = '0;
            seq_next      = '0;
            checksum_next = '0;
        end
    end

    // Page verdict, seen by the tracker on the closing byte
    always_comb
    begin
        status.done            = page_done;
        status.ok              = (magic_reg == record_magic) &&
                                 (need != '0) &&
                                 (length_reg == 16'(need)) &&
                                 (CMP_W'(off_after) >= need_end) &&
                                 ((crc_after ^ fsrs_pkg::CRC_INIT) == checksum_reg);
        status.sequence_no     = seq_reg;
        status.is_current      = version_reg == fsrs_pkg::VER_CURRENT;
        status.byte_not_erased = take && (item.data_byte != fsrs_pkg::ERASED_BYTE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= '0;
            crc_reg      <= fsrs_pkg::CRC_INIT;
            magic_reg    <= '0;
            version_reg  <= '0;
            length_reg   <= '0;
            seq_reg      <= '0;
            checksum_reg <= '0;
        end
        else
        begin
            offset_reg   <= offset_next;
            crc_reg      <= crc_next;
            magic_reg    <= magic_next;
            version_reg  <= version_next;
            length_reg   <= length_next;
            seq_reg      <= seq_next;
            checksum_reg <= checksum_next;
        end
    end

    `FSRS_ASSERT(a_offset_in_page, clk, rst_n, offset_reg <= OFF_W'(PAGE_BYTES), "offset ran past the page")
    `FSRS_ASSERT(a_page_end_clears, clk, rst_n, page_done |=> (offset_reg == '0 && crc_reg == fsrs_pkg::CRC_INIT), "page state not cleared after page end")

endmodule

`default_nettype wire

// ===== design/fsrs_best_tracker.sv =====
// Slot tracker: page index, valid mask, best record and erased flag per scan.
// Depends on fsrs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fsrs_best_tracker #(
    parameter int PAGE_COUNT = 4
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   fire,
    input  wire logic                   scan_end,
    input  wire fsrs_pkg::page_status_t status,
    output logic                        slot_active,
    output fsrs_pkg::result_t           result
);

    localparam int SLOT_W = $clog2(PAGE_COUNT + 1);

    logic [SLOT_W-1:0]     slot_reg,    slot_next,    slot_upd;
    logic [PAGE_COUNT-1:0] valid_reg,   valid_next,   valid_upd;
    logic                  found_reg,   found_next,   found_upd;
    logic [SLOT_W-1:0]     best_reg,    best_next,    best_upd;
    logic [31:0]           bseq_reg,    bseq_next,    bseq_upd;
    logic                  current_reg, current_next, current_upd;
    logic                  erased_reg,  erased_next,  erased_upd;
    logic [3:0]            mask_out;

    assign slot_active = slot_reg < SLOT_W'(PAGE_COUNT);

    // Fold the closing page, and the erased check of each byte, into the scan summary
    always_comb
    begin
        slot_upd    = slot_reg;
        valid_upd   = valid_reg;
        found_upd   = found_reg;
        best_upd    = best_reg;
        bseq_upd    = bseq_reg;
        current_upd = current_reg;
        erased_upd  = erased_reg && !status.byte_not_erased;
        if (status.done && slot_active)
        begin
            if (status.ok)
            begin
                valid_upd = valid_reg | (PAGE_COUNT'(1) << slot_reg);
                if (!found_reg || (status.sequence_no > bseq_reg))
                begin
                    found_upd   = 1'b1;
                    best_upd    = slot_reg;
                    bseq_upd    = status.sequence_no;
                    current_upd = status.is_current;
                end
            end
            slot_upd = slot_reg + SLOT_W'(1);
        end
    end

    // Low four pages of the mask reach the result
    for (genvar i = 0; i < 4; i++)
    begin : g_mask
        if (i < PAGE_COUNT)
        begin : g_bit
            assign mask_out[i] = valid_upd[i];
        end
        else
        begin : g_pad
            assign mask_out[i] = 1'b0;
        end
    end

    // Result of a scan, taken by the output register on scan end
    always_comb
    begin
        result.record_found    = found_upd;
        result.best_slot       = found_upd ? best_upd[1:0] : 2'd0;
        result.best_sequence   = found_upd ? bseq_upd : 32'd0;
        result.best_is_current = found_upd && current_upd;
        result.valid_mask      = mask_out;
        if (found_upd)
            result.boot_status = fsrs_pkg::BOOT_VALID;
        else if (erased_upd)
            result.boot_status = fsrs_pkg::BOOT_VIRGIN;
        else
            result.boot_status = fsrs_pkg::BOOT_CORRUPT;
    end

    // Drop the summary once the scan closes
    always_comb
    begin
        slot_next    = slot_upd;
        valid_next   = valid_upd;
        found_next   = found_upd;
        best_next    = best_upd;
        bseq_next    = bseq_upd;
        current_next = current_upd;
        erased_next  = erased_upd;
        if (fire && scan_end)
        begin
            slot_next    = '0;
            valid_next   = '0;
            found_next   = 1'b0;
            best_next    = '0;
            bseq_next    = '0;
            current_next = 1'b0;
            erased_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg    <= '0;
            valid_reg   <= '0;
            found_reg   <= 1'b0;
            best_reg    <= '0;
            bseq_reg    <= '0;
            current_reg <= 1'b0;
            erased_reg  <= 1'b1;
        end
        else
        begin
            slot_reg    <= slot_next;
            valid_reg   <= valid_next;
            found_reg   <= found_next;
            best_reg    <= best_next;
            bseq_reg    <= bseq_next;
            current_reg <= current_next;
            erased_reg  <= erased_next;
        end
    end

    `FSRS_ASSERT(a_found_matches_mask, clk, rst_n, found_reg == (valid_reg != '0), "best record flag disagrees with valid mask")
    `FSRS_NEVER(a_found_not_erased, clk, rst_n, found_reg && erased_reg, "valid record seen on an all-erased scan")

endmodule

`default_nettype wire

// ===== design/flash_record_slot_scanner.sv =====
// Flash record slot scanner, top level: input register, config registers,
// page parser, slot tracker and result register. Depends on fsrs_pkg,
// fsrs_page_parser, fsrs_best_tracker and assert_macros.svh.
//
// Usage:
//   in_*  : one page byte per transfer, page_end on the last byte of a page,
//           scan_end on the last byte of the scan (it also closes the page).
//   out_* : one result transfer per scan, carrying the best page, its
//           sequence and format, the valid mask and the boot status.
//   cfg_* : register writes, taken on any edge with cfg_we high; write only
//           while no scan byte is in flight.
//   Throughput is one byte per cycle while in_stall is low: the CRC byte step
//   and header capture sit between the input register and the page state registers.
//   out_valid rises when the result register loads from the scan_end byte
//   as it leaves the input register.
//   A stalled result is held; bytes keep flowing, and only a following
//   scan_end byte waits in the input register (in_stall) until the result
//   is taken.
//   Reset clears scan state and loads the default magic and legacy length.
`default_nettype none
`include "assert_macros.svh"

module flash_record_slot_scanner #(
    parameter int PAGE_COUNT = 4,
    parameter int PAGE_BYTES = 2048
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire fsrs_pkg::in_item_t                  in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output fsrs_pkg::result_t                        out_data,
    input  wire logic                                cfg_we,
    input  wire logic [fsrs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [fsrs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [31:0]                   magic_reg,  magic_next;
    logic [fsrs_pkg::LEGACY_W-1:0] legacy_reg, legacy_next;

    fsrs_pkg::in_item_t item_reg;
    logic               item_valid_reg, item_valid_next;
    fsrs_pkg::result_t  result_reg;
    logic               out_valid_reg, out_valid_next;

    logic                   advance;
    logic                   fire;
    logic                   in_take;
    logic                   result_load;
    logic                   slot_active;
    fsrs_pkg::page_status_t page_status;
    fsrs_pkg::result_t      scan_result;

    // Configuration writes
    always_comb
    begin
        magic_next  = magic_reg;
        legacy_next = legacy_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                fsrs_pkg::REG_RECORD_MAGIC: magic_next  = cfg_data;
                fsrs_pkg::REG_LEGACY_LEN:   legacy_next = cfg_data[fsrs_pkg::LEGACY_W-1:0];
                default:                    magic_next  = magic_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg  <= fsrs_pkg::MAGIC_RESET;
            legacy_reg <= fsrs_pkg::LEGACY_LEN_RESET;
        end
        else
        begin
            magic_reg  <= magic_next;
            legacy_reg <= legacy_next;
        end
    end

    // Input register: a held byte advances unless it closes a scan and the
    // result register is still blocked
    assign advance     = !item_reg.scan_end || !out_valid_reg || !out_stall;
    assign fire        = item_valid_reg && advance;
    assign in_stall    = item_valid_reg && !advance;
    assign in_take     = in_valid && !in_stall;
    assign result_load = fire && item_reg.scan_end;

    assign item_valid_next = in_take || (item_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            item_reg <= in_data;
    end

    fsrs_page_parser #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .item         (item_reg),
        .slot_active  (slot_active),
        .record_magic (magic_reg),
        .legacy_len   (legacy_reg),
        .status       (page_status)
    );

    fsrs_best_tracker #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .scan_end    (item_reg.scan_end),
        .status      (page_status),
        .slot_active (slot_active),
        .result      (scan_result)
    );

    // Result register: load on scan end, hold while stalled
    assign out_valid_next = result_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
            result_reg <= scan_result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = result_reg;

    `FSRS_NEVER(a_no_result_overwrite, clk, rst_n, result_load && out_valid_reg && out_stall, "pending result overwritten")
    `FSRS_ASSERT(a_stall_needs_item, clk, rst_n, in_stall |-> (item_valid_reg && item_reg.scan_end), "input stalled without a blocked scan end")
    `FSRS_ASSERT(a_result_source, clk, rst_n, $rose(out_valid_reg) |-> $past(result_load), "result appeared without a scan end transfer")

endmodule

`default_nettype wire
